// File: src/uhr_pkg.sv
`timescale 1ns / 1ps

package uhr_pkg;

  // Fixed field widths of the request and result channels
  localparam int OP_WIDTH    = 2;
  localparam int VALUE_WIDTH = 32;

  // Defaults for the top-level parameters
  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_ENTRY_WIDTH   = 32;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD  = 2'd0,
    OP_UNDO = 2'd1,
    OP_REDO = 2'd2,
    OP_READ = 2'd3
  } op_e;

  // ST_FETCH: a request waits on the RAM read, result register empty
  // ST_HOLD : result register full, nothing in flight
  // ST_BOTH : result register full and a request waiting behind it
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD,
    ST_BOTH
  } state_e;

  typedef struct packed {
    logic accept;    // take the request on the input side this cycle
    logic load_out;  // move the waiting request into the result register
  } ctrl_cmd_t;

endpackage

// File: src/uhr_ram.sv
`timescale 1ns / 1ps

module uhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/uhr_ctrl.sv
`timescale 1ns / 1ps

module uhr_ctrl
  import uhr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = in_valid_i ? ST_BOTH : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i) begin
          state_d = in_valid_i ? ST_FETCH : ST_IDLE;
        end else if (in_valid_i) begin
          state_d = ST_BOTH;
        end
      end
      ST_BOTH: begin
        if (out_ready_i) state_d = in_valid_i ? ST_BOTH : ST_HOLD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_FETCH: begin
        in_ready_o     = 1'b1;
        cmd_o.load_out = 1'b1;
      end
      ST_HOLD: begin
        in_ready_o  = 1'b1;
        out_valid_o = 1'b1;
      end
      ST_BOTH: begin
        in_ready_o     = out_ready_i;
        out_valid_o    = 1'b1;
        cmd_o.load_out = out_ready_i;
      end
      default: ;
    endcase
    cmd_o.accept = in_valid_i & in_ready_o;
  end

endmodule

// File: src/uhr_datapath.sv
`timescale 1ns / 1ps

module uhr_datapath
  import uhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int ENTRY_WIDTH   = DEF_ENTRY_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  input  logic [OP_WIDTH-1:0]    operation_i,
  input  logic [VALUE_WIDTH-1:0] entry_value_i,
  output logic [VALUE_WIDTH-1:0] current_value_o,
  output logic                   can_undo_o,
  output logic                   can_redo_o
);

  localparam int PtrW = $clog2(HISTORY_DEPTH);
  localparam logic [PtrW-1:0] LastPos = PtrW'(HISTORY_DEPTH - 1);

  logic [PtrW-1:0] cur_q, cur_d, old_q, old_d, new_q, new_d;
  logic [PtrW-1:0] cur_next, cur_prev, old_next;
  logic            zero_wr_q, zero_wr_d;
  logic            is_add;

  logic                   pend_add_q, pend_blank_q, pend_undo_q, pend_redo_q;
  logic [ENTRY_WIDTH-1:0] pend_wval_q;
  logic [ENTRY_WIDTH-1:0] wdata, rdata, sel_val;
  logic [VALUE_WIDTH-1:0] value_q, value_ext;
  logic                   undo_q, redo_q;

  // Fit the request value to the stored width, and the stored value to the result
  if (ENTRY_WIDTH <= VALUE_WIDTH) begin : g_narrow
    assign wdata     = entry_value_i[ENTRY_WIDTH-1:0];
    assign value_ext = {{(VALUE_WIDTH - ENTRY_WIDTH){1'b0}}, sel_val};
  end else begin : g_wide
    assign wdata     = {{(ENTRY_WIDTH - VALUE_WIDTH){1'b0}}, entry_value_i};
    assign value_ext = sel_val[VALUE_WIDTH-1:0];
  end

  assign cur_next = (cur_q == LastPos) ? '0 : cur_q + 1'b1;
  assign cur_prev = (cur_q == '0) ? LastPos : cur_q - 1'b1;
  assign old_next = (old_q == LastPos) ? '0 : old_q + 1'b1;

  always_comb begin
    cur_d  = cur_q;
    old_d  = old_q;
    new_d  = new_q;
    is_add = 1'b0;
    unique case (op_e'(operation_i))
      OP_ADD: begin
        is_add = 1'b1;
        cur_d  = cur_next;
        new_d  = cur_next;
        if (cur_next == old_q) old_d = old_next;
      end
      OP_UNDO: begin
        if (cur_q != old_q) cur_d = cur_prev;
      end
      OP_REDO: begin
        if (cur_q != new_q) cur_d = cur_next;
      end
      OP_READ: ;
      default: ;
    endcase
    zero_wr_d = zero_wr_q | (is_add & (cur_next == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      old_q     <= '0;
      new_q     <= '0;
      zero_wr_q <= 1'b0;
    end else if (cmd_i.accept) begin
      cur_q     <= cur_d;
      old_q     <= old_d;
      new_q     <= new_d;
      zero_wr_q <= zero_wr_d;
    end
  end

  uhr_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept & is_add),
    .waddr_i (cur_next),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept & ~is_add),
    .raddr_i (cur_d),
    .rdata_o (rdata)
  );

  // Slot zero reads as cleared until the first add lands there
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_add_q   <= is_add;
      pend_wval_q  <= wdata;
      pend_blank_q <= (cur_d == '0) & ~zero_wr_q;
      pend_undo_q  <= cur_d != old_d;
      pend_redo_q  <= cur_d != new_d;
    end
  end

  always_comb begin
    if (pend_add_q) begin
      sel_val = pend_wval_q;
    end else if (pend_blank_q) begin
      sel_val = '0;
    end else begin
      sel_val = rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q <= value_ext;
      undo_q  <= pend_undo_q;
      redo_q  <= pend_redo_q;
    end
  end

  assign current_value_o = value_q;
  assign can_undo_o      = undo_q;
  assign can_redo_o      = redo_q;

endmodule

// File: src/undo_redo_history_ring.sv
// Undo/redo history ring: a circular history of HISTORY_DEPTH entries with
// oldest, current and newest positions. Each request carries an operation
// (add, undo, redo, read) and, for add, the value of the new entry; each
// request returns exactly one result with the entry now current and the
// can_undo / can_redo flags. Add discards any redo entries and drops the
// oldest entry once the ring is full. Requests are taken one per cycle
// while the result side is not stalled; a result passes through the
// registered read port of the history RAM and then into the result
// register. At most one request waits behind a held result, so a stalled
// output side stops the input side after one further request. Slot zero
// reads as cleared after reset through a single written flag, so there is
// no clearing pass and the block is ready straight out of reset.
`timescale 1ns / 1ps

module undo_redo_history_ring
  import uhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int ENTRY_WIDTH   = DEF_ENTRY_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_WIDTH-1:0]    operation_i,
  input  logic [VALUE_WIDTH-1:0] entry_value_i,
  // result side
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] current_value_o,
  output logic                   can_undo_o,
  output logic                   can_redo_o
);

  ctrl_cmd_t cmd;

  // Controller: track the request in flight and the held result, and
  // decide when to take a request and when to advance the result register.
  uhr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: pointers, history RAM and result register. Pointers advance
  // as the request is taken, so the next request sees them at once.
  uhr_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .entry_value_i   (entry_value_i),
    .current_value_o (current_value_o),
    .can_undo_o      (can_undo_o),
    .can_redo_o      (can_redo_o)
  );

endmodule

// File: src/uhr_checker.sv
`timescale 1ns / 1ps

module uhr_checker
  import uhr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [VALUE_WIDTH-1:0] current_value_o,
  input logic                   can_undo_o,
  input logic                   can_redo_o
);

  logic [1:0] open_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Requests taken whose result has not yet been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != 2'd0)
    else $error("result offered with no request outstanding");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("more than two requests outstanding");

  a_idle_takes_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == 2'd0 |-> in_ready_o)
    else $error("idle block refuses a request");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_value_o)
      && $stable(can_undo_o) && $stable(can_redo_o))
    else $error("stalled result changed");

endmodule

bind undo_redo_history_ring uhr_checker u_uhr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .current_value_o (current_value_o),
  .can_undo_o      (can_undo_o),
  .can_redo_o      (can_redo_o)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the undo/redo history ring. A directed table opens the run
// (empty history, undo and redo at the ends, redo entries discarded by an
// add, a full ring wrapping over its oldest entry), then biased random
// segments push the positions to both ends of the kept range many times.
// Every result is checked against a typed expectation or a local model of the ring.
module tb;
  import uhr_pkg::*;

  localparam int HIST_DEPTH     = DEF_HISTORY_DEPTH;
  localparam int POS_W          = $clog2(HIST_DEPTH);
  localparam int DIRECTED_ITEMS = 26;
  localparam int RANDOM_ITEMS   = 1324;
  localparam int CALM_ITEMS     = 200;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   can_undo;
    logic                   can_redo;
  } hist_result_t;

  // One directed request; typed_res is used only where typed is set,
  // otherwise the ring model supplies the expected result.
  typedef struct packed {
    op_e                    op;
    logic [VALUE_WIDTH-1:0] value;
    logic                   typed;
    hist_result_t           typed_res;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [OP_WIDTH-1:0]    operation_i;
  logic [VALUE_WIDTH-1:0] entry_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [VALUE_WIDTH-1:0] current_value_o;
  logic                   can_undo_o;
  logic                   can_redo_o;

  // Local copy of the ring state
  logic [VALUE_WIDTH-1:0] hist_mem [HIST_DEPTH];
  logic [POS_W-1:0]       cur_pos;
  logic [POS_W-1:0]       old_pos;
  logic [POS_W-1:0]       new_pos;

  hist_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  bit           calm = 1'b0;     // no idling on either side
  bit           gap_on = 1'b1;   // sender may pause in this segment

  dir_row_t directed_rows [DIRECTED_ITEMS] = '{
    // empty history: undo and redo both stay on slot zero
    '{OP_READ, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_UNDO, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_REDO, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ADD,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{OP_UNDO, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{OP_REDO, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    // redo at the newest entry holds the position
    '{OP_REDO, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{OP_UNDO, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    // add after an undo discards the redo entry
    '{OP_ADD,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{OP_REDO, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    // fill the remaining slots
    '{OP_ADD,  32'h8000_0000, 1'b0, '0},
    '{OP_ADD,  32'h0000_0001, 1'b0, '0},
    '{OP_ADD,  32'h5555_5555, 1'b0, '0},
    '{OP_ADD,  32'hAAAA_AAAA, 1'b0, '0},
    '{OP_ADD,  32'h0123_4567, 1'b0, '0},
    '{OP_ADD,  32'h89AB_CDEF, 1'b0, '0},
    '{OP_ADD,  32'h7FFF_FFFF, 1'b0, '0},
    '{OP_ADD,  32'h0000_FFFF, 1'b0, '0},
    '{OP_ADD,  32'hFFFF_0000, 1'b0, '0},
    '{OP_ADD,  32'h0F0F_0F0F, 1'b0, '0},
    '{OP_ADD,  32'hF0F0_F0F0, 1'b0, '0},
    '{OP_ADD,  32'h3333_3333, 1'b0, '0},
    '{OP_ADD,  32'hCCCC_CCCC, 1'b0, '0},
    '{OP_ADD,  32'hDEAD_BEEF, 1'b0, '0},
    // ring full: this add overwrites the oldest entry in slot zero
    '{OP_ADD,  32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1, 1'b0}},
    '{OP_READ, 32'h0000_0000, 1'b1, '{32'h1234_5678, 1'b1, 1'b0}}
  };

  undo_redo_history_ring dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .current_value_o(current_value_o),
    .can_undo_o     (can_undo_o),
    .can_redo_o     (can_redo_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the local ring and return the result it yields.
  // Positions are POS_W bits wide, so they wrap round the ring by themselves.
  function automatic hist_result_t history_apply(op_e op, logic [VALUE_WIDTH-1:0] val);
    hist_result_t res;
    case (op)
      OP_ADD: begin
        new_pos = cur_pos + 1'b1;
        cur_pos = new_pos;
        if (new_pos == old_pos) old_pos = old_pos + 1'b1;
        hist_mem[cur_pos] = val;
      end
      OP_UNDO: if (cur_pos != old_pos) cur_pos = cur_pos - 1'b1;
      OP_REDO: if (cur_pos != new_pos) cur_pos = cur_pos + 1'b1;
      default: ;
    endcase
    res.value    = hist_mem[cur_pos];
    res.can_undo = (cur_pos != old_pos);
    res.can_redo = (cur_pos != new_pos);
    return res;
  endfunction

  // Hold the request until it is taken, then record what it must return.
  task automatic issue_request(input op_e op, input logic [VALUE_WIDTH-1:0] val,
                               input logic use_typed, input hist_result_t typed_res);
    hist_result_t predicted;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    entry_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = history_apply(op, val);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_gap();
    if (!calm && gap_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every outstanding result has come back.
  // Always wait for the clock here before checking, so valid is not lowered
  // and raised again within one step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned bias;
    int unsigned pick;
    int unsigned add_lim;
    int unsigned undo_lim;
    int unsigned redo_lim;
    op_e         op;
    logic [VALUE_WIDTH-1:0] val;

    in_valid_i    <= 1'b0;
    operation_i   <= OP_READ;
    entry_value_i <= '0;
    rst_ni        <= 1'b0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    cur_pos = '0;
    old_pos = '0;
    new_pos = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      sender_gap();
      issue_request(directed_rows[i].op, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].typed_res);
    end
    drain_results();

    // Random segments, each leaning towards one operation so the current
    // position runs into both ends of the kept range and the ring wraps.
    bias = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 24 == 0) begin
        bias   = $urandom_range(0, 3);
        gap_on = ($urandom_range(0, 2) != 0);
      end
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case (bias)
        0: begin add_lim = 30; undo_lim = 60; redo_lim = 85; end
        1: begin add_lim = 75; undo_lim = 85; redo_lim = 95; end
        2: begin add_lim = 15; undo_lim = 85; redo_lim = 95; end
        default: begin add_lim = 15; undo_lim = 40; redo_lim = 95; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < add_lim)       op = OP_ADD;
      else if (pick < undo_lim) op = OP_UNDO;
      else if (pick < redo_lim) op = OP_REDO;
      else                      op = OP_READ;
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      sender_gap();
      issue_request(op, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("undo_redo_history_ring test passed");
    end else begin
      $display("undo_redo_history_ring test failed");
    end
    $finish;
  end

  // Result side: hold ready high for random stretches with stall bursts
  // between them; no stalls once the run turns calm.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    hist_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: value %h undo %b redo %b",
                 $time, current_value_o, can_undo_o, can_redo_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (current_value_o !== want.value) begin
          $display("%0t: current_value expected %h actual %h",
                   $time, want.value, current_value_o);
          mismatch_count++;
        end
        if (can_undo_o !== want.can_undo) begin
          $display("%0t: can_undo expected %b actual %b", $time, want.can_undo, can_undo_o);
          mismatch_count++;
        end
        if (can_redo_o !== want.can_redo) begin
          $display("%0t: can_redo expected %b actual %b", $time, want.can_redo, can_redo_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("undo_redo_history_ring test failed");
    $finish;
  end

endmodule
